/* hw/rtl/mwpo_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwpo_pkg
// Shared constants, register and waveform codes, and the sine table function
// of the multi-waveform phase oscillator.
// ----------------------------------------------------------------------------
package mwpo_pkg;

   localparam int PHASE_BITS_DEF     = 32;
   localparam int SINE_ADDR_BITS_DEF = 10;
   localparam int SAMPLE_BITS_DEF    = 16;

   localparam int NEW_PHASE_W = 32;
   localparam int PHASE_OUT_W = 32;
   localparam int AMP_W       = 15;
   localparam int WAVE_W      = 2;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_ADDR_W-1:0] REG_PHASE_INC = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_AMPLITUDE = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_WAVEFORM  = 2'd2;

   localparam logic [WAVE_W-1:0] WAVE_SINE     = 2'd0;
   localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 2'd1;
   localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 2'd2;

   localparam logic [63:0] Q30_ONE  = 64'd1073741824;
   localparam logic [63:0] SIN_K1   = 64'd1686629713;
   localparam logic [63:0] SIN_K3   = 64'd693598671;
   localparam logic [63:0] SIN_K5   = 64'd85569306;
   localparam logic [63:0] SIN_K7   = 64'd5026994;
   localparam logic [63:0] SIN_K9   = 64'd172272;

   // quarter-wave entry: odd polynomial in Q30, clamp to one, scale, round half up
   function automatic logic [63:0] sine_entry(input logic [63:0] k, input int addr_bits,
                                              input int sample_bits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] full;
      x    = k << (30 - addr_bits);
      x2   = (x * x) >> 30;
      t    = SIN_K9;
      t    = SIN_K7 - ((x2 * t) >> 30);
      t    = SIN_K5 - ((x2 * t) >> 30);
      t    = SIN_K3 - ((x2 * t) >> 30);
      t    = SIN_K1 - ((x2 * t) >> 30);
      s    = (x * t) >> 30;
      if (s > Q30_ONE) begin
         s = Q30_ONE;
      end
      full = (64'd1 << (sample_bits - 1)) - 64'd1;
      return (s * full + (Q30_ONE >> 1)) >> 30;
   endfunction

endpackage

/* hw/rtl/mwpo_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwpo_req_if
// Request channel: advance tick or phase load word.
// ----------------------------------------------------------------------------
interface mwpo_req_if;
   import mwpo_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   mode;
   logic [NEW_PHASE_W-1:0] new_phase;

   modport source (output valid, output mode, output new_phase, input ready);
   modport sink   (input valid, input mode, input new_phase, output ready);

endinterface

/* hw/rtl/mwpo_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwpo_rsp_if
// Result channel: one sample and the phase it was taken at.
// ----------------------------------------------------------------------------
interface mwpo_rsp_if #(
   parameter int SAMPLE_BITS = mwpo_pkg::SAMPLE_BITS_DEF
);
   import mwpo_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic [PHASE_OUT_W-1:0]        phase_out;

   modport source (output valid, output sample_out, output phase_out, input ready);
   modport sink   (input valid, input sample_out, input phase_out, output ready);

endinterface

/* hw/rtl/mwpo_shape.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwpo_shape
// Shape stage: quarter-wave sine ROM, square sign and triangle level, all
// registered; gives the unsigned level and its sign for the selected shape.
// ----------------------------------------------------------------------------
module mwpo_shape #(
   parameter int PHASE_BITS     = mwpo_pkg::PHASE_BITS_DEF,
   parameter int SINE_ADDR_BITS = mwpo_pkg::SINE_ADDR_BITS_DEF,
   parameter int SAMPLE_BITS    = mwpo_pkg::SAMPLE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           load,
   input  logic [PHASE_BITS-1:0]          phase,
   input  logic [mwpo_pkg::WAVE_W-1:0]    waveform,
   output logic [SAMPLE_BITS-2:0]         mag,
   output logic                           neg
);
   import mwpo_pkg::*;

   localparam int MAG_W     = SAMPLE_BITS - 1;
   localparam int ROM_DEPTH = (1 << SINE_ADDR_BITS) + 1;
   localparam int TRI_W     = 31 + MAG_W;

   localparam logic [MAG_W-1:0]          FULL     = {MAG_W{1'b1}};
   localparam logic [SINE_ADDR_BITS:0]   K_TOP    = {1'b1, {SINE_ADDR_BITS{1'b0}}};
   localparam logic [PHASE_BITS-1:0]     HALF     = {1'b1, {(PHASE_BITS-1){1'b0}}};
   localparam logic [31:0]               Q30      = 32'h4000_0000;
   localparam logic [TRI_W-1:0]          TRI_RND  = TRI_W'(32'h2000_0000);

   logic [MAG_W-1:0]          sine_rom [ROM_DEPTH];
   logic [1:0]                quad;
   logic [SINE_ADDR_BITS-1:0] addr;
   logic [SINE_ADDR_BITS:0]   rom_k;
   logic [PHASE_BITS-1:0]     span;
   logic [PHASE_BITS+29:0]    span_ext;
   logic [29:0]               span30;
   logic [31:0]               four;
   logic                      tri_neg;
   logic [31:0]               tri_m;
   logic [TRI_W-1:0]          tri_prod;
   logic [MAG_W-1:0]          tri_mag;
   logic                      sq_neg;
   logic [MAG_W-1:0]          alt_in;
   logic                      neg_in;

   logic [MAG_W-1:0]          rom_ff;
   logic [MAG_W-1:0]          alt_ff;
   logic                      neg_ff;

   for (genvar i = 0; i < ROM_DEPTH; i++) begin : g_rom
      assign sine_rom[i] = MAG_W'(sine_entry(64'(i), SINE_ADDR_BITS, SAMPLE_BITS));
   end

   assign quad   = phase[PHASE_BITS-1 -: 2];
   assign addr   = phase[PHASE_BITS-3 -: SINE_ADDR_BITS];
   assign rom_k  = quad[0] ? (K_TOP - {1'b0, addr}) : {1'b0, addr};

   assign sq_neg = !((phase != '0) && !phase[PHASE_BITS-1]);

   assign span     = phase[PHASE_BITS-1] ? {1'b0, phase[PHASE_BITS-2:0]} : (HALF - phase);
   assign span_ext = {span, 30'b0};
   assign span30   = span_ext[PHASE_BITS+29:PHASE_BITS];
   assign four     = {span30, 2'b00};
   assign tri_neg  = four > Q30;
   assign tri_m    = tri_neg ? (four - Q30) : (Q30 - four);
   assign tri_prod = TRI_W'(tri_m[30:0]) * TRI_W'(FULL) + TRI_RND;
   assign tri_mag  = tri_prod[29+MAG_W:30];

   always_comb begin
      case (waveform)
         WAVE_SINE: begin
            alt_in = '0;
            neg_in = quad[1];
         end
         WAVE_SQUARE: begin
            alt_in = FULL;
            neg_in = sq_neg;
         end
         WAVE_TRIANGLE: begin
            alt_in = tri_mag;
            neg_in = tri_neg;
         end
         default: begin
            alt_in = '0;
            neg_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rom_ff <= sine_rom[rom_k];
         alt_ff <= alt_in;
         neg_ff <= neg_in;
      end
   end

   assign mag = (waveform == WAVE_SINE) ? rom_ff : alt_ff;
   assign neg = neg_ff;

endmodule

/* hw/rtl/multi_waveform_phase_oscillator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_waveform_phase_oscillator_top
// Phase-accumulator oscillator giving sine, square or triangle samples
// scaled by a programmable amplitude.
// A tick word passes the phase, shape/ROM and sample registers on its way to rsp.
// Throughput: one word per cycle while rsp is ready; three register stages
// (phase, shape/ROM, amplitude multiply) each hold or advance on their own.
// Phase load words update the accumulator and give no result.
// Reset (synchronous): phase, increment, amplitude and waveform to zero.
// ----------------------------------------------------------------------------
module multi_waveform_phase_oscillator_top #(
   parameter int PHASE_BITS     = mwpo_pkg::PHASE_BITS_DEF,
   parameter int SINE_ADDR_BITS = mwpo_pkg::SINE_ADDR_BITS_DEF,
   parameter int SAMPLE_BITS    = mwpo_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   mwpo_req_if.sink                          req_ch,
   mwpo_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [mwpo_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [mwpo_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mwpo_pkg::*;

   localparam int MAG_W  = SAMPLE_BITS - 1;
   localparam int PROD_W = MAG_W + AMP_W + 1;
   localparam logic [PROD_W-1:0] AMP_RND = PROD_W'(16384);

   logic [PHASE_BITS-1:0]  phase_ff;
   logic [PHASE_BITS-1:0]  phase_in;
   logic [PHASE_BITS-1:0]  inc_ff;
   logic [AMP_W-1:0]       amp_ff;
   logic [WAVE_W-1:0]      wave_ff;

   logic                   s1_vld_ff;
   logic [PHASE_BITS-1:0]  s1_phase_ff;
   logic                   s2_vld_ff;
   logic [PHASE_BITS-1:0]  s2_phase_ff;
   logic                   rsp_vld_ff;
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [SAMPLE_BITS-1:0] sample_in;
   logic [PHASE_OUT_W-1:0] phase_out_ff;

   logic                   s1_ready;
   logic                   s2_ready;
   logic                   s3_ready;
   logic                   req_fire;
   logic [MAG_W-1:0]       mag;
   logic                   neg;
   logic [PROD_W-1:0]      prod;
   logic [SAMPLE_BITS-1:0] scaled;

   assign s3_ready = !rsp_vld_ff || rsp_ch.ready;
   assign s2_ready = !s2_vld_ff || s3_ready;
   assign s1_ready = !s1_vld_ff || s2_ready;
   assign req_fire = req_ch.valid && s1_ready;

   assign req_ch.ready = s1_ready;

   assign phase_in = req_ch.mode ? PHASE_BITS'(req_ch.new_phase) : (phase_ff + inc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         inc_ff  <= '0;
         amp_ff  <= '0;
         wave_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_PHASE_INC: inc_ff  <= PHASE_BITS'(csr_wdata);
            REG_AMPLITUDE: amp_ff  <= csr_wdata[AMP_W-1:0];
            REG_WAVEFORM:  wave_ff <= csr_wdata[WAVE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff <= phase_in;
         end
         if (s1_ready) begin
            s1_vld_ff <= req_fire && !req_ch.mode;
         end
         if (s2_ready) begin
            s2_vld_ff <= s1_vld_ff;
         end
         if (s3_ready) begin
            rsp_vld_ff <= s2_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_phase_ff <= phase_in;
      end
      if (s2_ready) begin
         s2_phase_ff <= s1_phase_ff;
      end
      if (s3_ready) begin
         sample_ff    <= sample_in;
         phase_out_ff <= PHASE_OUT_W'(s2_phase_ff);
      end
   end

   mwpo_shape #(
      .PHASE_BITS     (PHASE_BITS),
      .SINE_ADDR_BITS (SINE_ADDR_BITS),
      .SAMPLE_BITS    (SAMPLE_BITS)
   ) u_shape (
      .clock    (clock),
      .load     (s2_ready),
      .phase    (s1_phase_ff),
      .waveform (wave_ff),
      .mag      (mag),
      .neg      (neg)
   );

   assign prod      = PROD_W'(mag) * PROD_W'(amp_ff) + AMP_RND;
   assign scaled    = {1'b0, prod[MAG_W+AMP_W-1:AMP_W]};
   assign sample_in = neg ? (SAMPLE_BITS'(0) - scaled) : scaled;

   assign rsp_ch.valid      = rsp_vld_ff;
   assign rsp_ch.sample_out = sample_ff;
   assign rsp_ch.phase_out  = phase_out_ff;

endmodule
